// File: src/fhp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhp_pkg
// Shared types and constants for the stream header parser.
// ----------------------------------------------------------------------------
package fhp_pkg;

    localparam int OFFSET_BITS = 32;          // width of the stream byte counter
    localparam int INFO_LEN    = 34;          // STREAMINFO bytes captured
    localparam int MIN_TOTAL   = 42;          // shortest valid buffer
    localparam int POS_BITS    = 24;
    localparam int CAP_IDX_W   = $clog2(INFO_LEN);

    localparam logic [7:0] HDR_LAST_MASK = 8'h80;
    localparam logic [7:0] HDR_TYPE_MASK = 8'h7F;

    typedef enum logic [1:0] {
        PH_MAGIC,
        PH_HEADER,
        PH_PAYLOAD,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_TRUNCATED = 3'd2,
        ST_NO_INFO   = 3'd3,
        ST_SHORT     = 3'd4
    } t_status;

    typedef logic [INFO_LEN-1:0][7:0] t_capture;   // byte i at index i

    // result payload, first member in the top bits
    typedef struct packed {
        logic [5:0]  pad;
        logic [31:0] used_bytes;
        logic [63:0] digest_low;
        logic [63:0] digest_high;
        logic [35:0] sample_count;
        logic [5:0]  sample_bits;
        logic [3:0]  channel_count;
        logic [19:0] rate_hz;
        logic [23:0] frame_max;
        logic [23:0] frame_min;
        logic [15:0] block_max;
        logic [15:0] block_min;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h66;   // 'f'
            2'd1:    v = 8'h4C;   // 'L'
            2'd2:    v = 8'h61;   // 'a'
            default: v = 8'h43;   // 'C'
        endcase
        return v;
    endfunction

endpackage

// File: src/fhp_unpack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhp_unpack
// Splits the captured STREAMINFO bytes into the result fields.
// ----------------------------------------------------------------------------
module fhp_unpack
    import fhp_pkg::*;
(
    input  t_capture               i_cap,
    input  t_status                i_status,
    input  logic [OFFSET_BITS-1:0] i_consumed,
    output t_result                o_result
);

    logic [31:0] w_bytes;

    // saturate the byte count to 32 bits
    generate
        if (OFFSET_BITS > 32) begin : g_sat
            assign w_bytes = (|i_consumed[OFFSET_BITS-1:32]) ? 32'hFFFF_FFFF
                                                             : i_consumed[31:0];
        end else begin : g_nosat
            assign w_bytes = 32'(i_consumed);
        end
    endgenerate

    always_comb begin
        o_result = '0;
        if (i_status == ST_OK) begin
            o_result.block_min     = {i_cap[0], i_cap[1]};
            o_result.block_max     = {i_cap[2], i_cap[3]};
            o_result.frame_min     = {i_cap[4], i_cap[5], i_cap[6]};
            o_result.frame_max     = {i_cap[7], i_cap[8], i_cap[9]};
            o_result.rate_hz       = {i_cap[10], i_cap[11], i_cap[12][7:4]};
            o_result.channel_count = {1'b0, i_cap[12][3:1]} + 4'd1;
            o_result.sample_bits   = {1'b0, i_cap[12][0], i_cap[13][7:4]} + 6'd1;
            o_result.sample_count  = {i_cap[13][3:0], i_cap[14], i_cap[15],
                                      i_cap[16], i_cap[17]};
            o_result.digest_high   = {i_cap[18], i_cap[19], i_cap[20], i_cap[21],
                                      i_cap[22], i_cap[23], i_cap[24], i_cap[25]};
            o_result.digest_low    = {i_cap[26], i_cap[27], i_cap[28], i_cap[29],
                                      i_cap[30], i_cap[31], i_cap[32], i_cap[33]};
            o_result.used_bytes    = w_bytes;
        end
    end

endmodule

// File: src/flac_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flac_header_parser
// Walks the magic and metadata block headers of an audio stream and reports
// the STREAMINFO contents.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one stream byte per item in tdata, tlast high on
//   the last byte of the supplied buffer.
//   Output stream (m_axis_*): at most one result item per buffer, carrying the
//   decoded STREAMINFO fields in tdata and the status code in tuser. It is
//   raised when the last-flagged block completes, at end of data, or at once
//   on a bad magic byte; bytes after that are dropped up to tlast.
//   Path: a byte is registered in the input register on acceptance, passes
//   through the combinational parse step, and its result is loaded into the
//   result register that drives tvalid.
//   Throughput: one byte per cycle unless a held result stalls it; each byte
//   is a single pass through the parse step from input to result register.
//   Stall: a held result stops only a byte that would cause another result;
//   while that byte waits in the input register tready drops.
//   Reset: synchronous, active low; parser returns to the magic check and
//   both registers empty. Each tlast byte also returns the parser to that
//   state. The STREAMINFO capture bytes are not reset.
// ----------------------------------------------------------------------------
module flac_header_parser
    import fhp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // byte_value[7:0]
    input  logic                s_axis_tlast,   // end_of_data
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // tdata from bit 0: block_min 16, block_max 16, frame_min 24,
    // frame_max 24, rate_hz 20, channel_count 4, sample_bits 6,
    // sample_count 36, digest_high 64, digest_low 64, used_bytes 32, zeros 6
    output logic [RESULT_W-1:0] m_axis_tdata,
    output logic [2:0]          m_axis_tuser    // status[2:0]
);

    localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;

    // input register
    logic                   r_in_valid;
    logic [7:0]             r_byte;
    logic                   r_eod;

    // parser state
    t_phase                 r_phase, n_phase;
    logic [OFFSET_BITS-1:0] r_ofs, n_ofs;
    logic [POS_BITS-1:0]    r_pos, n_pos;
    logic [POS_BITS-1:0]    r_len, n_len;
    logic                   r_final, n_final;
    logic                   r_info, n_info;
    logic                   r_found, n_found;
    t_capture               r_cap;

    // result register
    logic                   r_out_valid;
    logic [RESULT_W-1:0]    r_out_data;
    t_status                r_out_status;

    logic                   w_go;
    logic                   w_emit;
    t_status                w_status;
    logic [OFFSET_BITS-1:0] w_consumed;
    logic [OFFSET_BITS-1:0] w_total;
    logic                   w_cap_we;
    logic                   w_complete;
    t_capture               w_cap_now;
    t_result                w_result;

    // the byte in the input register moves on unless it makes a result that
    // would land on one still held
    assign w_go          = r_in_valid && (!w_emit || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_go;

    // ---------------------------------------------------------------- step
    always_comb begin
        n_phase    = r_phase;
        n_ofs      = r_ofs;
        n_pos      = r_pos;
        n_len      = r_len;
        n_final    = r_final;
        n_info     = r_info;
        n_found    = r_found;
        w_emit     = 1'b0;
        w_status   = ST_OK;
        w_consumed = '0;
        w_cap_we   = 1'b0;
        w_complete = 1'b0;
        w_total    = (r_ofs != OFS_MAX) ? r_ofs + 1'b1 : r_ofs;

        if (r_phase == PH_DONE) begin
            // dropping bytes; tlast restarts
            if (r_eod) begin
                n_phase = PH_MAGIC;
                n_ofs   = '0;
                n_pos   = '0;
                n_len   = '0;
                n_final = 1'b0;
                n_info  = 1'b0;
                n_found = 1'b0;
            end
        end else begin
            case (r_phase)
                PH_MAGIC: begin
                    if (r_byte != magic_byte(r_pos[1:0])) begin
                        w_emit   = 1'b1;
                        w_status = ST_BAD_MAGIC;
                    end else if (r_pos[1:0] == 2'd3) begin
                        n_pos   = '0;
                        n_phase = PH_HEADER;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
                PH_HEADER: begin
                    if (r_pos[1:0] == 2'd0) begin
                        n_final = (r_byte & HDR_LAST_MASK) != 8'h00;
                        n_info  = (r_byte & HDR_TYPE_MASK) == 8'h00;
                        n_len   = '0;
                    end else begin
                        n_len = {r_len[POS_BITS-9:0], r_byte};
                    end
                    if (r_pos[1:0] == 2'd3) begin
                        n_pos = '0;
                        if (n_len == '0) begin
                            w_complete = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
                default: begin
                    // payload: capture the head of a long enough STREAMINFO
                    w_cap_we = r_info && (r_len >= POS_BITS'(INFO_LEN))
                               && (r_pos < POS_BITS'(INFO_LEN));
                    n_pos    = r_pos + 1'b1;
                    if (n_pos == r_len) begin
                        w_complete = 1'b1;
                    end
                end
            endcase

            if (w_complete) begin
                n_pos   = '0;
                n_phase = PH_HEADER;
                if (n_info && (n_len >= POS_BITS'(INFO_LEN))) begin
                    n_found = 1'b1;
                end
                if (n_final) begin
                    w_emit     = 1'b1;
                    w_status   = n_found ? ST_OK : ST_NO_INFO;
                    w_consumed = w_total;
                end
            end

            n_ofs = w_total;

            if (r_eod) begin
                if (w_total < OFFSET_BITS'(MIN_TOTAL)) begin
                    // too short wins over everything on this byte
                    w_emit   = 1'b1;
                    w_status = ST_SHORT;
                end else if (!w_emit) begin
                    w_emit = 1'b1;
                    case (n_phase)
                        PH_PAYLOAD: w_status = ST_TRUNCATED;
                        PH_HEADER: begin
                            // end between blocks: offset of the last whole block
                            w_status   = n_found ? ST_OK : ST_NO_INFO;
                            w_consumed = (w_total == OFS_MAX) ? OFS_MAX
                                       : w_total - OFFSET_BITS'(n_pos);
                        end
                        default:    w_status = ST_NO_INFO;
                    endcase
                end
            end

            if (w_emit) begin
                if (r_eod) begin
                    n_phase = PH_MAGIC;
                    n_ofs   = '0;
                    n_pos   = '0;
                    n_len   = '0;
                    n_final = 1'b0;
                    n_info  = 1'b0;
                    n_found = 1'b0;
                end else begin
                    n_phase = PH_DONE;
                end
            end
        end
    end

    // the completing byte may itself be the last capture byte
    always_comb begin
        for (int i = 0; i < INFO_LEN; i++) begin
            w_cap_now[i] = (w_cap_we && (r_pos[CAP_IDX_W-1:0] == CAP_IDX_W'(i)))
                         ? r_byte : r_cap[i];
        end
    end

    fhp_unpack u_unpack (
        .i_cap      (w_cap_now),
        .i_status   (w_status),
        .i_consumed (w_consumed),
        .o_result   (w_result)
    );

    // ----------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_byte <= s_axis_tdata;
            r_eod  <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_ofs   <= '0;
            r_pos   <= '0;
            r_len   <= '0;
            r_final <= 1'b0;
            r_info  <= 1'b0;
            r_found <= 1'b0;
        end else if (w_go) begin
            r_phase <= n_phase;
            r_ofs   <= n_ofs;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_final <= n_final;
            r_info  <= n_info;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_cap_we) begin
            r_cap[r_pos[CAP_IDX_W-1:0]] <= r_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_emit) begin
            r_out_data   <= w_result;
            r_out_status <= w_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    // ---------------------------------------------------------- assertions
    a_done_silent : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_phase == PH_DONE) |-> !w_emit)
        else $error("result raised while dropping bytes");

    a_ok_needs_info : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_status == ST_OK) |-> n_found || r_eod)
        else $error("ok status without a captured STREAMINFO block");

    a_magic_pos : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MAGIC || r_phase == PH_HEADER) |-> r_pos < POS_BITS'(4))
        else $error("header position out of range");

    a_hold_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_go) |=> (r_in_valid && $stable(r_byte) && $stable(r_eod)))
        else $error("stalled byte lost from the input register");

    a_fail_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> r_out_data == '0)
        else $error("failed result carries field data");

endmodule

// File: test/tb_flac_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flac_header_parser
// Self-checking bench for the stream header parser. Whole buffers (magic,
// metadata blocks, noise) are queued as byte items and pushed through the
// input stream with random gaps. A local parser model predicts each header
// result, which is checked field by field against the output stream. The
// receiver stalls at random, and once holds off long enough to back the
// block up.
// ----------------------------------------------------------------------------
module tb_flac_header_parser;
    import fhp_pkg::*;

    localparam logic [31:0] MAGIC_WORD = 32'h664C6143;   // "fLaC", first byte on top
    localparam int RANDOM_BYTES = 1300;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int HOLD_AFTER   = 12;    // results checked before the hold-off
    localparam int STALL_LIMIT  = 4000;  // idle cycles before giving up
    localparam int TAIL_CYCLES  = 8;
    localparam int MAX_REPORTS  = 40;

    // payload fill patterns
    localparam int FILL_RAND  = 0;
    localparam int FILL_ONES  = 1;
    localparam int FILL_ZEROS = 2;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_item;

    typedef struct packed {
        t_status st;
        t_result res;
    } t_expect;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;   // byte_value[7:0]
    logic                s_axis_tlast;   // end_of_data
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // from bit 0: min/max block size, min/max frame size, sample rate, channels,
    // sample bits, total samples, digest high/low, bytes consumed, zero pad
    logic [RESULT_W-1:0] m_axis_tdata;
    logic [2:0]          m_axis_tuser;   // status[2:0]

    flac_header_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // stimulus and expectations
    logic [7:0] frame_bytes[$];      // buffer under construction
    t_item      pending_items[$];    // bytes waiting for the driver
    t_expect    expected_headers[$];

    // parser model state
    t_phase                 walk_phase;
    logic [OFFSET_BITS-1:0] byte_count;
    logic [POS_BITS-1:0]    part_pos;
    logic [POS_BITS-1:0]    blk_len;
    logic                   blk_is_last;
    logic                   blk_is_info;
    logic                   info_seen;
    t_capture               info_bytes;

    // bookkeeping
    int      errors;
    int      frames_built;
    int      bytes_seen;
    int      headers_checked;
    int      status_hits[5];
    int      quiet_cycles;
    int      items_sent;
    int      src_gap;
    int      sink_gap;
    int      sink_cycles;
    int      hold_left;
    logic    hold_armed;
    logic    hold_done;
    logic    in_taken;
    t_item   cur_item;
    logic    pred_got;
    t_expect pred_hdr;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------
    task automatic clear_walk();
        walk_phase  = PH_MAGIC;
        byte_count  = '0;
        part_pos    = '0;
        blk_len     = '0;
        blk_is_last = 1'b0;
        blk_is_info = 1'b0;
        info_seen   = 1'b0;
        // capture bytes keep their contents, as in hardware
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic eod,
                              output logic got, output t_expect hdr);
        logic [OFFSET_BITS-1:0] total;
        logic [OFFSET_BITS-1:0] used;
        logic                   blk_done;
        int                     i;
        got      = 1'b0;
        hdr      = '0;
        hdr.st   = ST_OK;
        used     = '0;
        blk_done = 1'b0;
        if (walk_phase == PH_DONE) begin
            // dropping bytes until end of buffer
            if (eod)
                clear_walk();
        end else begin
            total = (byte_count != '1) ? byte_count + 1'b1 : byte_count;
            case (walk_phase)
                PH_MAGIC: begin
                    if (b != MAGIC_WORD[31 - 8 * part_pos[1:0] -: 8]) begin
                        got    = 1'b1;
                        hdr.st = ST_BAD_MAGIC;
                    end else if (part_pos == 3) begin
                        part_pos   = '0;
                        walk_phase = PH_HEADER;
                    end else begin
                        part_pos = part_pos + 1'b1;
                    end
                end
                PH_HEADER: begin
                    if (part_pos == 0) begin
                        blk_is_last = (b & HDR_LAST_MASK) != 0;
                        blk_is_info = (b & HDR_TYPE_MASK) == 0;
                        blk_len     = '0;
                    end else begin
                        blk_len = {blk_len[15:0], b};
                    end
                    if (part_pos == 3) begin
                        part_pos = '0;
                        if (blk_len == 0)
                            blk_done = 1'b1;   // empty block ends on its header
                        else
                            walk_phase = PH_PAYLOAD;
                    end else begin
                        part_pos = part_pos + 1'b1;
                    end
                end
                default: begin
                    // only full-size STREAMINFO blocks are captured
                    if (blk_is_info && blk_len >= INFO_LEN && part_pos < INFO_LEN)
                        info_bytes[part_pos[5:0]] = b;
                    part_pos = part_pos + 1'b1;
                    if (part_pos == blk_len)
                        blk_done = 1'b1;
                end
            endcase

            if (blk_done) begin
                part_pos   = '0;
                walk_phase = PH_HEADER;
                if (blk_is_info && blk_len >= INFO_LEN)
                    info_seen = 1'b1;
                if (blk_is_last) begin
                    got = 1'b1;
                    if (info_seen)
                        hdr.st = ST_OK;
                    else
                        hdr.st = ST_NO_INFO;
                    used = total;
                end
            end

            byte_count = total;

            if (eod) begin
                if (total < MIN_TOTAL) begin
                    // short buffer overrides whatever else this byte did
                    got    = 1'b1;
                    hdr.st = ST_SHORT;
                end else if (!got) begin
                    got = 1'b1;
                    if (walk_phase == PH_PAYLOAD) begin
                        hdr.st = ST_TRUNCATED;
                    end else if (walk_phase == PH_HEADER) begin
                        if (info_seen)
                            hdr.st = ST_OK;
                        else
                            hdr.st = ST_NO_INFO;
                        // back up to the start of the partial header
                        used = (total == '1) ? total : total - part_pos;
                    end else begin
                        hdr.st = ST_NO_INFO;
                    end
                end
            end

            if (got && hdr.st == ST_OK) begin
                hdr.res.block_min     = {info_bytes[0], info_bytes[1]};
                hdr.res.block_max     = {info_bytes[2], info_bytes[3]};
                hdr.res.frame_min     = {info_bytes[4], info_bytes[5], info_bytes[6]};
                hdr.res.frame_max     = {info_bytes[7], info_bytes[8], info_bytes[9]};
                hdr.res.rate_hz       = {info_bytes[10], info_bytes[11],
                                         info_bytes[12][7:4]};
                hdr.res.channel_count = {1'b0, info_bytes[12][3:1]} + 4'd1;
                hdr.res.sample_bits   = {1'b0, info_bytes[12][0], info_bytes[13][7:4]}
                                        + 6'd1;
                hdr.res.sample_count  = {info_bytes[13][3:0], info_bytes[14],
                                         info_bytes[15], info_bytes[16], info_bytes[17]};
                for (i = 0; i < 8; i++) begin
                    hdr.res.digest_high = {hdr.res.digest_high[55:0], info_bytes[18 + i]};
                    hdr.res.digest_low  = {hdr.res.digest_low[55:0], info_bytes[26 + i]};
                end
                hdr.res.used_bytes = used[31:0];
            end

            if (eod)
                clear_walk();
            else if (got)
                walk_phase = PH_DONE;
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    task automatic check_header_result(input t_result got, input logic [2:0] got_st);
        t_expect want;
        if (expected_headers.size() == 0) begin
            report_mismatch("result with none pending, status", 64'(got_st), 64'(0));
        end else begin
            want = expected_headers.pop_front();
            headers_checked++;
            status_hits[want.st]++;
            if (headers_checked == HOLD_AFTER)
                hold_armed = 1'b1;
            if (got_st !== want.st)
                report_mismatch("status", 64'(got_st), 64'(want.st));
            if (got.block_min !== want.res.block_min)
                report_mismatch("block_min", 64'(got.block_min), 64'(want.res.block_min));
            if (got.block_max !== want.res.block_max)
                report_mismatch("block_max", 64'(got.block_max), 64'(want.res.block_max));
            if (got.frame_min !== want.res.frame_min)
                report_mismatch("frame_min", 64'(got.frame_min), 64'(want.res.frame_min));
            if (got.frame_max !== want.res.frame_max)
                report_mismatch("frame_max", 64'(got.frame_max), 64'(want.res.frame_max));
            if (got.rate_hz !== want.res.rate_hz)
                report_mismatch("rate_hz", 64'(got.rate_hz), 64'(want.res.rate_hz));
            if (got.channel_count !== want.res.channel_count)
                report_mismatch("channel_count", 64'(got.channel_count),
                                64'(want.res.channel_count));
            if (got.sample_bits !== want.res.sample_bits)
                report_mismatch("sample_bits", 64'(got.sample_bits),
                                64'(want.res.sample_bits));
            if (got.sample_count !== want.res.sample_count)
                report_mismatch("sample_count", 64'(got.sample_count),
                                64'(want.res.sample_count));
            if (got.digest_high !== want.res.digest_high)
                report_mismatch("digest_high", got.digest_high, want.res.digest_high);
            if (got.digest_low !== want.res.digest_low)
                report_mismatch("digest_low", got.digest_low, want.res.digest_low);
            if (got.used_bytes !== want.res.used_bytes)
                report_mismatch("used_bytes", 64'(got.used_bytes),
                                64'(want.res.used_bytes));
        end
    endtask

    // ------------------------------------------------------------------------
    // Buffer construction
    // ------------------------------------------------------------------------
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic put_random(input int n);
        int i;
        for (i = 0; i < n; i++)
            frame_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic put_magic();
        int i;
        for (i = 0; i < 4; i++)
            frame_bytes.push_back(MAGIC_WORD[31 - 8 * i -: 8]);
    endtask

    task automatic put_header(input logic last, input logic [6:0] btype,
                              input logic [23:0] len);
        frame_bytes.push_back({last, btype});
        frame_bytes.push_back(len[23:16]);
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);
    endtask

    task automatic put_block(input logic last, input logic [6:0] btype, input int len,
                             input int fill);
        int i;
        put_header(last, btype, 24'(len));
        for (i = 0; i < len; i++) begin
            case (fill)
                FILL_ONES:  frame_bytes.push_back(8'hFF);
                FILL_ZEROS: frame_bytes.push_back(8'h00);
                default:    frame_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic trim_frame(input int keep);
        while (frame_bytes.size() > keep)
            void'(frame_bytes.pop_back());
    endtask

    // hand the buffer to the driver, tlast on its final byte
    task automatic close_frame();
        int    i;
        t_item it;
        for (i = 0; i < frame_bytes.size(); i++) begin
            it.data = frame_bytes[i];
            it.last = (i == frame_bytes.size() - 1);
            pending_items.push_back(it);
        end
        frame_bytes.delete();
        frames_built++;
    endtask

    // mostly sane metadata chains with random content and endings
    task automatic build_stream();
        int         nblk;
        int         i;
        int         pick;
        int         len;
        logic       last;
        logic [6:0] btype;
        logic       cut_short;
        put_magic();
        nblk      = $urandom_range(1, 4);
        cut_short = 1'b0;
        for (i = 0; i < nblk && !cut_short; i++) begin
            last = (i == nblk - 1) && ($urandom_range(0, 9) < 8);
            pick = $urandom_range(0, 19);
            if (pick < 8) begin
                btype = 7'd0;
                len   = $urandom_range(INFO_LEN, INFO_LEN + 6);
            end else if (pick < 10) begin
                btype = 7'd0;
                len   = $urandom_range(0, INFO_LEN - 1);
            end else if (pick < 19) begin
                btype = 7'($urandom_range(1, 127));
                len   = $urandom_range(0, 24);
            end else begin
                // huge length that the buffer never fills
                put_header(last, 7'($urandom_range(0, 127)),
                           24'($urandom_range(256, 24'hFFFFFF)));
                put_random($urandom_range(0, 10));
                cut_short = 1'b1;
            end
            if (!cut_short)
                put_block(last, btype, len, FILL_RAND);
        end
        if (!cut_short) begin
            put_random($urandom_range(0, 4));
            if ($urandom_range(0, 3) == 0)
                trim_frame($urandom_range(1, frame_bytes.size()));
        end
        close_frame();
    endtask

    task automatic build_bad_magic();
        int pos;
        pos = $urandom_range(0, 3);
        put_magic();
        frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
        put_random($urandom_range(0, 56));
        trim_frame($urandom_range(pos + 1, frame_bytes.size()));
        close_frame();
    endtask

    task automatic build_stimulus();
        int target;
        // largest field values; the block ends on the buffer's last byte
        put_magic(); put_block(1'b1, 7'd0, INFO_LEN, FILL_ONES); close_frame();
        // smallest field values; trailing bytes after the result are dropped
        put_magic(); put_block(1'b1, 7'd0, INFO_LEN, FILL_ZEROS); put_random(3); close_frame();
        // bad magic on the first byte of a long buffer
        frame_bytes.push_back(8'h00); put_random(44); close_frame();
        // bad magic on a lone byte: too short takes precedence
        frame_bytes.push_back(8'hFF); close_frame();
        // bad magic on the last magic byte
        put_magic(); frame_bytes[3] = 8'h00; put_random(50); close_frame();
        // good start, buffer below the minimum length
        put_magic(); put_block(1'b1, 7'd0, INFO_LEN, FILL_RAND); trim_frame(30); close_frame();
        // empty block, undersized STREAMINFO skipped, then a real one
        put_magic();
        put_block(1'b0, 7'd5, 0, FILL_RAND);
        put_block(1'b0, 7'd0, 10, FILL_RAND);
        put_block(1'b1, 7'd0, 36, FILL_RAND);
        close_frame();
        // last block reached without any STREAMINFO
        put_magic(); put_block(1'b1, 7'h7F, 40, FILL_RAND); close_frame();
        // end of buffer inside a payload
        put_magic(); put_block(1'b0, 7'd0, 50, FILL_RAND); trim_frame(45); close_frame();
        // maximum length field, payload cut off
        put_magic(); put_header(1'b0, 7'd0, 24'hFFFFFF); put_random(40); close_frame();
        // end inside a header after a complete STREAMINFO
        put_magic(); put_block(1'b0, 7'd0, INFO_LEN, FILL_RAND); put_random(2); close_frame();
        // end on a block boundary, no last flag, no STREAMINFO
        put_magic(); put_block(1'b0, 7'd1, 40, FILL_RAND); close_frame();
        // second STREAMINFO replaces the first; empty last block closes the chain
        put_magic();
        put_block(1'b0, 7'd0, INFO_LEN, FILL_RAND);
        put_block(1'b0, 7'd0, 38, FILL_RAND);
        put_block(1'b1, 7'd0, 0, FILL_RAND);
        close_frame();

        target = pending_items.size() + RANDOM_BYTES;
        while (pending_items.size() < target) begin
            case ($urandom_range(0, 19))
                0, 1, 2:  build_bad_magic();
                3, 4: begin
                    put_random($urandom_range(1, 60));
                    close_frame();
                end
                default:  build_stream();
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Input driver: new item at the falling edge once the last one is taken
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                cur_item = pending_items.pop_front();
                s_axis_tdata  <= cur_item.data;
                s_axis_tlast  <= cur_item.last;
                s_axis_tvalid <= 1'b1;
                items_sent++;
                // every fourth stretch of items goes back to back
                src_gap = (((items_sent / 150) % 4) == 3) ? 0 : idle_len();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output sink: random stalls, plus one long hold-off to back the block up
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        sink_cycles++;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (((sink_cycles / 500) % 3) == 2 || $urandom_range(0, 3) != 0)
                sink_gap = 0;
            else
                sink_gap = idle_len();
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on every accepted byte, check every accepted result
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                bytes_seen++;
                parse_byte(s_axis_tdata, s_axis_tlast, pred_got, pred_hdr);
                if (pred_got)
                    expected_headers.push_back(pred_hdr);
            end
            if (m_axis_tvalid && m_axis_tready)
                check_header_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        in_taken      = 1'b0;
        errors        = 0;
        frames_built  = 0;
        bytes_seen    = 0;
        headers_checked = 0;
        status_hits   = '{default: 0};
        quiet_cycles  = 0;
        items_sent    = 0;
        src_gap       = 0;
        sink_gap      = 0;
        sink_cycles   = 0;
        hold_left     = 0;
        hold_armed    = 1'b0;
        hold_done     = 1'b0;
        info_bytes    = '0;
        clear_walk();
        build_stimulus();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (expected_headers.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d buffers, %0d bytes, %0d results checked", frames_built, bytes_seen,
                 headers_checked);
        $display("ok %0d, bad magic %0d, truncated %0d, no streaminfo %0d, too short %0d",
                 status_hits[ST_OK], status_hits[ST_BAD_MAGIC], status_hits[ST_TRUNCATED],
                 status_hits[ST_NO_INFO], status_hits[ST_SHORT]);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
src/fhp_pkg.sv
src/fhp_unpack.sv
src/flac_header_parser.sv
test/tb_flac_header_parser.sv
